FILE: rtl/core/ncs_pkg.sv
// Shared types and constants for the nearest codeword search block.
// Used by ncs_search and nearest_codeword_search; depends on nothing.
`timescale 1ns / 1ps

package ncs_pkg;

  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned ELEM_IDX_W = 4;
  localparam int unsigned DIST_W     = 36;
  localparam int unsigned ENT_REG_W  = 9;
  localparam int unsigned BLEN_REG_W = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [DIST_W-1:0]     DIST_MAX = {DIST_W{1'b1}};
  localparam logic [ENT_REG_W-1:0]  ENT_RST  = 9'd256;
  localparam logic [BLEN_REG_W-1:0] BLEN_RST = 5'd16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = 2'd1;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [ENT_REG_W-1:0]  entries;
    logic [BLEN_REG_W-1:0] blen;
  } search_req_t;

  typedef struct packed {
    logic               busy;
    logic               valid;
    logic [INDEX_W-1:0] index;
    logic [DIST_W-1:0]  distance;
  } search_rsp_t;

endpackage

FILE: rtl/core/ncs_store.sv
// Codebook memory and query buffer, one write and one registered read port each.
// Stand-alone; the search sequencer drives the read addresses.
`timescale 1ns / 1ps

module ncs_store #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned ADDR_W       = 12,
  parameter int unsigned QADDR_W      = 4
) (
  input  logic                    clk_i,
  input  logic                    cb_we_i,
  input  logic [ADDR_W-1:0]       cb_waddr_i,
  input  logic                    q_we_i,
  input  logic [QADDR_W-1:0]      q_waddr_i,
  input  logic [SAMPLE_WIDTH-1:0] wdata_i,
  input  logic [ADDR_W-1:0]       cb_raddr_i,
  input  logic [QADDR_W-1:0]      q_raddr_i,
  output logic [SAMPLE_WIDTH-1:0] cb_rdata_o,
  output logic [SAMPLE_WIDTH-1:0] q_rdata_o
);

  localparam int unsigned CB_DEPTH = 1 << ADDR_W;
  localparam int unsigned Q_DEPTH  = 1 << QADDR_W;

  logic [SAMPLE_WIDTH-1:0] cb_mem [CB_DEPTH];
  logic [SAMPLE_WIDTH-1:0] q_mem  [Q_DEPTH];
  logic [SAMPLE_WIDTH-1:0] cb_rdata_q;
  logic [SAMPLE_WIDTH-1:0] q_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cb_we_i) begin
      cb_mem[cb_waddr_i] <= wdata_i;
    end
    cb_rdata_q <= cb_mem[cb_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (q_we_i) begin
      q_mem[q_waddr_i] <= wdata_i;
    end
    q_rdata_q <= q_mem[q_raddr_i];
  end

  assign cb_rdata_o = cb_rdata_q;
  assign q_rdata_o  = q_rdata_q;

endmodule

FILE: rtl/core/ncs_search.sv
// Search sequencer: walks entries and elements, squares differences,
// accumulates per entry and keeps the nearest one. Uses ncs_pkg types.
`timescale 1ns / 1ps

module ncs_search #(
  parameter int unsigned MAX_ENTRIES  = 256,
  parameter int unsigned MAX_DIM      = 16,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ncs_pkg::search_req_t            req_i,
  input  logic                            ack_i,
  output ncs_pkg::search_rsp_t            rsp_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]  e_raddr_o,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] k_raddr_o,
  input  logic [SAMPLE_WIDTH-1:0]         cb_rdata_i,
  input  logic [SAMPLE_WIDTH-1:0]         q_rdata_i
);

  localparam int unsigned EIW = $clog2(MAX_ENTRIES);
  localparam int unsigned KW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DW  = $clog2(MAX_DIM + 1);
  localparam int unsigned AW  = 2 * SAMPLE_WIDTH + DW;
  localparam int unsigned XW  = (AW > ncs_pkg::DIST_W) ? AW : ncs_pkg::DIST_W;

  // Issue stage
  logic           run_q, run_d;
  logic [EIW-1:0] e_q, e_d;
  logic [KW-1:0]  k_q, k_d;
  logic [EIW-1:0] cntm1_q, cntm1_d;
  logic [KW-1:0]  dimm1_q, dimm1_d;
  logic           lk0, le0;
  logic [12:0]    ent_x;
  logic [6:0]     dim_x;

  // Pipeline tags
  logic           v1_q, v2_q, v3_q;
  logic           lk1_q, lk2_q, lk3_q;
  logic           le1_q, le2_q, le3_q;
  logic [EIW-1:0] e1_q, e2_q, e3_q;

  // Datapath
  logic signed [SAMPLE_WIDTH:0]     diff_d, diff_q;
  logic signed [2*SAMPLE_WIDTH+1:0] prod;
  logic [2*SAMPLE_WIDTH-1:0]        sq_q;
  logic [AW-1:0]                    acc_q, sum;
  logic [XW-1:0]                    sum_x;
  logic [ncs_pkg::DIST_W-1:0]       dist_sat;
  logic                             take;

  // Result
  logic                       done_q;
  logic [EIW-1:0]             best_e_q;
  logic [ncs_pkg::DIST_W-1:0] best_d_q;

  always_comb begin
    ent_x = (req_i.entries == '0) ? 13'd1 : 13'(req_i.entries);
    if (ent_x > 13'(MAX_ENTRIES)) begin
      ent_x = 13'(MAX_ENTRIES);
    end
    dim_x = (req_i.blen == '0) ? 7'd1 : 7'(req_i.blen);
    if (dim_x > 7'(MAX_DIM)) begin
      dim_x = 7'(MAX_DIM);
    end
    cntm1_d = EIW'(ent_x - 13'd1);
    dimm1_d = KW'(dim_x - 7'd1);

    lk0   = (k_q == dimm1_q);
    le0   = lk0 && (e_q == cntm1_q);
    run_d = run_q;
    e_d   = e_q;
    k_d   = k_q;
    if (req_i.start) begin
      run_d = 1'b1;
      e_d   = '0;
      k_d   = '0;
    end else if (run_q) begin
      if (lk0) begin
        k_d = '0;
        e_d = e_q + EIW'(1);
      end else begin
        k_d = k_q + KW'(1);
      end
      if (le0) begin
        run_d = 1'b0;
      end
    end
  end

  assign e_raddr_o = e_q;
  assign k_raddr_o = k_q;

  assign diff_d   = {q_rdata_i[SAMPLE_WIDTH-1], q_rdata_i}
                  - {cb_rdata_i[SAMPLE_WIDTH-1], cb_rdata_i};
  assign prod     = diff_q * diff_q;
  assign sum      = acc_q + AW'(sq_q);
  assign sum_x    = XW'(sum);
  assign dist_sat = (sum_x > XW'(ncs_pkg::DIST_MAX)) ? ncs_pkg::DIST_MAX
                                                     : sum_x[ncs_pkg::DIST_W-1:0];
  // Strict compare keeps the lower index on ties
  assign take     = (e3_q == '0) || (dist_sat < best_d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      e_q    <= '0;
      k_q    <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q <= run_d;
      e_q   <= e_d;
      k_q   <= k_d;
      v1_q  <= run_q;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      if (v3_q && le3_q) begin
        done_q <= 1'b1;
      end else if (ack_i) begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      cntm1_q <= cntm1_d;
      dimm1_q <= dimm1_d;
      acc_q   <= '0;
    end
    lk1_q  <= lk0;
    le1_q  <= le0;
    e1_q   <= e_q;
    lk2_q  <= lk1_q;
    le2_q  <= le1_q;
    e2_q   <= e1_q;
    diff_q <= diff_d;
    lk3_q  <= lk2_q;
    le3_q  <= le2_q;
    e3_q   <= e2_q;
    sq_q   <= prod[2*SAMPLE_WIDTH-1:0];
    if (v3_q) begin
      if (lk3_q) begin
        acc_q <= '0;
        if (take) begin
          best_e_q <= e3_q;
          best_d_q <= dist_sat;
        end
      end else begin
        acc_q <= sum;
      end
    end
  end

  assign rsp_o.busy     = run_q | v1_q | v2_q | v3_q | done_q;
  assign rsp_o.valid    = done_q;
  assign rsp_o.index    = ncs_pkg::INDEX_W'(best_e_q);
  assign rsp_o.distance = best_d_q;

endmodule

FILE: rtl/core/nearest_codeword_search.sv
// Full-search vector quantizer encoder: nearest codebook entry to a query block.
// Loads and query elements without the last mark are taken while in_stall_o is low.
// A last query element starts a search, which reads one element per cycle through the
// codebook memory read port; no item is taken until its result is shown.
// Reset clears control and sets entries_in_use to 256, block_length to 16;
// memories are not cleared.
`timescale 1ns / 1ps

module nearest_codeword_search #(
  parameter int unsigned MAX_ENTRIES  = 256,
  parameter int unsigned MAX_DIM      = 16,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic [ncs_pkg::INDEX_W-1:0]        entry_index_i,
  input  logic [ncs_pkg::ELEM_IDX_W-1:0]     element_index_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_value_i,
  input  logic                               last_element_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ncs_pkg::INDEX_W-1:0]        best_index_o,
  output logic [ncs_pkg::DIST_W-1:0]         best_distance_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ncs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ncs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned EIW = $clog2(MAX_ENTRIES);
  localparam int unsigned KW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [ncs_pkg::ENT_REG_W-1:0]  entries_q;
  logic [ncs_pkg::BLEN_REG_W-1:0] blen_q;

  logic                 in_acc, ent_ok, elem_ok, cb_we, q_we;
  logic [EIW-1:0]       e_raddr;
  logic [KW-1:0]        k_raddr;
  logic [SAMPLE_WIDTH-1:0] cb_rdata, q_rdata;

  ncs_pkg::search_req_t req;
  ncs_pkg::search_rsp_t rsp;
  logic                 out_free, res_ack;

  logic                       out_valid_q, out_valid_d;
  logic [ncs_pkg::INDEX_W-1:0] out_index_q;
  logic [ncs_pkg::DIST_W-1:0]  out_dist_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= ncs_pkg::ENT_RST;
      blen_q    <= ncs_pkg::BLEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ncs_pkg::CFG_ENTRIES:   entries_q <= cfg_data_i;
        ncs_pkg::CFG_BLOCK_LEN: blen_q    <= cfg_data_i[ncs_pkg::BLEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off inputs for the whole search and until its result has moved on
  assign in_stall_o = rsp.busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ent_ok     = 13'(entry_index_i) < 13'(MAX_ENTRIES);
  assign elem_ok    = 7'(element_index_i) < 7'(MAX_DIM);
  assign cb_we      = in_acc && (opcode_i == ncs_pkg::OP_LOAD) && ent_ok && elem_ok;
  assign q_we       = in_acc && (opcode_i == ncs_pkg::OP_QUERY) && elem_ok;

  assign req.start   = in_acc && (opcode_i == ncs_pkg::OP_QUERY) && last_element_i;
  assign req.entries = entries_q;
  assign req.blen    = blen_q;

  ncs_store #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ADDR_W       (EIW + KW),
    .QADDR_W      (KW)
  ) u_store (
    .clk_i      (clk_i),
    .cb_we_i    (cb_we),
    .cb_waddr_i ({EIW'(entry_index_i), KW'(element_index_i)}),
    .q_we_i     (q_we),
    .q_waddr_i  (KW'(element_index_i)),
    .wdata_i    (sample_value_i),
    .cb_raddr_i ({e_raddr, k_raddr}),
    .q_raddr_i  (k_raddr),
    .cb_rdata_o (cb_rdata),
    .q_rdata_o  (q_rdata)
  );

  ncs_search #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_DIM      (MAX_DIM),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .ack_i      (res_ack),
    .rsp_o      (rsp),
    .e_raddr_o  (e_raddr),
    .k_raddr_o  (k_raddr),
    .cb_rdata_i (cb_rdata),
    .q_rdata_i  (q_rdata)
  );

  // Output register frees the search as soon as the result is taken over
  assign out_free    = !out_valid_q || !out_stall_i;
  assign res_ack     = rsp.valid && out_free;
  assign out_valid_d = res_ack || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_index_q <= rsp.index;
      out_dist_q  <= rsp.distance;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign best_index_o    = out_index_q;
  assign best_distance_o = out_dist_q;

  a_no_result_after_start : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    req.start |=> !rsp.valid && rsp.busy
  ) else $error("result raised right after a search start");

  a_out_from_search : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(rsp.valid)
  ) else $error("output valid without a finished search");

  a_result_held : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !res_ack |=> rsp.valid && $stable(rsp.index) && $stable(rsp.distance)
  ) else $error("pending search result changed before transfer");

  a_no_write_while_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    rsp.busy |-> !cb_we && !q_we
  ) else $error("memory written during a search");

endmodule
